FILE: hdl/frustum_cull_test_assert.svh
// Assertion macros shared by the culling block.
`ifndef FRUSTUM_CULL_TEST_ASSERT_SVH
`define FRUSTUM_CULL_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fct assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fct assertion failed");

`endif

FILE: hdl/fct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

  localparam int PLANES      = 6;
  localparam int CORNERS     = 8;
  localparam int COORD_W     = 20;
  localparam int FIELD_W     = 20;
  localparam int RADIUS_W    = 19;
  localparam int REG_W       = 63;
  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int ALIGN_SHIFT = 19;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int OFF_W       = FIELD_W + 1;
  localparam int DIST_W      = 43;

  // Register indexes of the packed offsets.
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_FIRST  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_SECOND = 3'd7;

  typedef enum logic {
    OP_BOX    = 1'b0,
    OP_SPHERE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE = 2'd0,
    VERDICT_PARTIAL = 2'd1,
    VERDICT_INSIDE  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a;
    logic signed [FIELD_W-1:0] b;
    logic signed [FIELD_W-1:0] c;
    logic signed [FIELD_W-1:0] d;
  } plane_t;

  // Per-plane classification handed from a lane to the verdict logic.
  typedef struct packed {
    logic none_pos;
    logic all_pos;
    logic sphere_out;
  } plane_stat_t;

endpackage

`default_nettype wire

FILE: hdl/fct_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module fct_cfg_regs import fct_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [REG_W-1:0]         cfg_wdata,
  output plane_t    [PLANES-1:0]        planes_o
);

  logic [REG_W-1:0] regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  // Unpack normals and offsets; bits 62:60 are dropped here.
  for (genvar p = 0; p < PLANES; p++) begin : g_plane
    localparam int SLOT = p % 3;
    localparam logic [CFG_IDX_W-1:0] OIDX = (p < 3) ? REG_OFFS_FIRST : REG_OFFS_SECOND;
    assign planes_o[p].a = regs_r[p][FIELD_W-1:0];
    assign planes_o[p].b = regs_r[p][2*FIELD_W-1:FIELD_W];
    assign planes_o[p].c = regs_r[p][3*FIELD_W-1:2*FIELD_W];
    assign planes_o[p].d = regs_r[OIDX][SLOT*FIELD_W +: FIELD_W];
  end

endmodule

`default_nettype wire

FILE: hdl/fct_plane_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_lane import fct_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       load_i,
  input  wire logic                       sphere_i,
  input  wire plane_t                     plane_i,
  input  wire logic signed [COORD_W-1:0]  lo_x_i,
  input  wire logic signed [COORD_W-1:0]  lo_y_i,
  input  wire logic signed [COORD_W-1:0]  lo_z_i,
  input  wire logic signed [COORD_W-1:0]  hi_x_i,
  input  wire logic signed [COORD_W-1:0]  hi_y_i,
  input  wire logic signed [COORD_W-1:0]  hi_z_i,
  input  wire logic        [RADIUS_W-1:0] radius_i,
  output plane_stat_t                     stat_o
);

  logic signed [PROD_W-1:0] plx_r, ply_r, plz_r, phx_r, phy_r, phz_r;
  logic signed [OFF_W-1:0]  off_r, off_nxt, rad_term;
  logic signed [OFF_W+ALIGN_SHIFT-1:0] off_shift;
  logic signed [DIST_W-1:0] corner_dist [CORNERS];
  logic [CORNERS-1:0]       pos;

  // A sphere folds its radius into the offset, so a negative center distance means outside.
  assign rad_term = sphere_i ? $signed({2'b00, radius_i}) : '0;
  assign off_nxt  = OFF_W'(plane_i.d) + rad_term;

  always_ff @(posedge clk) begin
    if (load_i) begin
      plx_r <= plane_i.a * lo_x_i;
      ply_r <= plane_i.b * lo_y_i;
      plz_r <= plane_i.c * lo_z_i;
      phx_r <= plane_i.a * hi_x_i;
      phy_r <= plane_i.b * hi_y_i;
      phz_r <= plane_i.c * hi_z_i;
      off_r <= off_nxt;
    end
  end

  assign off_shift = {off_r, ALIGN_SHIFT'(0)};

  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      corner_dist[k] = DIST_W'(k[0] ? phx_r : plx_r) + DIST_W'(k[1] ? phy_r : ply_r)
                     + DIST_W'(k[2] ? phz_r : plz_r) + DIST_W'(off_shift);
      pos[k]  = !corner_dist[k][DIST_W-1] && (corner_dist[k] != '0);
    end
  end

  // Corner zero is built from the low operands, which carry the center for a sphere.
  assign stat_o.none_pos   = (pos == '0);
  assign stat_o.all_pos    = &pos;
  assign stat_o.sphere_out = corner_dist[0][DIST_W-1];

endmodule

`default_nettype wire

FILE: hdl/frustum_cull_test.sv
// Pipeline: an accepted input beat passes the input register, product register
//   and verdict register before out_valid.
// Throughput: one beat per cycle unless out_ready stalls; six plane lanes
//   work in parallel, six 20x20 multipliers each, so every beat makes one pass.
// Reset: rst_n synchronous, active low; clears all pipeline valid bits and
//   the eight plane registers to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_cull_test_assert.svh"

module frustum_cull_test import fct_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration write port
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [REG_W-1:0]           cfg_wdata,
  // query channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_operation,
  input  wire logic signed [COORD_W-1:0]  in_min_x,
  input  wire logic signed [COORD_W-1:0]  in_min_y,
  input  wire logic signed [COORD_W-1:0]  in_min_z,
  input  wire logic signed [COORD_W-1:0]  in_max_x,
  input  wire logic signed [COORD_W-1:0]  in_max_y,
  input  wire logic signed [COORD_W-1:0]  in_max_z,
  input  wire logic signed [COORD_W-1:0]  in_center_x,
  input  wire logic signed [COORD_W-1:0]  in_center_y,
  input  wire logic signed [COORD_W-1:0]  in_center_z,
  input  wire logic        [RADIUS_W-1:0] in_radius,
  // verdict channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [1:0]          out_verdict
);

  plane_t      [PLANES-1:0] planes;
  plane_stat_t [PLANES-1:0] stats;

  // Stage valid bits.
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  logic load2;

  // Stage 1 payload: a sphere parks its center in the low operands.
  logic                       sphere1_r, sphere2_r;
  logic signed [COORD_W-1:0]  lo_x_r, lo_y_r, lo_z_r, hi_x_r, hi_y_r, hi_z_r;
  logic        [RADIUS_W-1:0] radius1_r;
  logic                       sphere_nxt;

  logic                       any_none, all_full, any_sphere_out;
  verdict_t                   verdict_nxt;
  logic                [1:0]  verdict_r;

  fct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .planes_o  (planes)
  );

  // Each stage advances when the stage after it is empty or moving on.
  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign load2    = v1_r && adv2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  assign sphere_nxt = (in_operation == OP_SPHERE);

  // Capture the beat; hold while stage 2 is stalled.
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      sphere1_r <= sphere_nxt;
      lo_x_r    <= sphere_nxt ? in_center_x : in_min_x;
      lo_y_r    <= sphere_nxt ? in_center_y : in_min_y;
      lo_z_r    <= sphere_nxt ? in_center_z : in_min_z;
      hi_x_r    <= in_max_x;
      hi_y_r    <= in_max_y;
      hi_z_r    <= in_max_z;
      radius1_r <= in_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) sphere2_r <= sphere1_r;
  end

  // One lane per plane: products registered in stage 2, corner tests after.
  for (genvar p = 0; p < PLANES; p++) begin : g_lane
    fct_plane_lane u_lane (
      .clk      (clk),
      .load_i   (load2),
      .sphere_i (sphere1_r),
      .plane_i  (planes[p]),
      .lo_x_i   (lo_x_r),
      .lo_y_i   (lo_y_r),
      .lo_z_i   (lo_z_r),
      .hi_x_i   (hi_x_r),
      .hi_y_i   (hi_y_r),
      .hi_z_i   (hi_z_r),
      .radius_i (radius1_r),
      .stat_o   (stats[p])
    );
  end

  // Combine the six plane results into one verdict.
  always_comb begin
    any_none       = 1'b0;
    all_full       = 1'b1;
    any_sphere_out = 1'b0;
    for (int p = 0; p < PLANES; p++) begin
      any_none       = any_none | stats[p].none_pos;
      all_full       = all_full & stats[p].all_pos;
      any_sphere_out = any_sphere_out | stats[p].sphere_out;
    end
    if (sphere2_r) begin
      verdict_nxt = any_sphere_out ? VERDICT_OUTSIDE : VERDICT_PARTIAL;
    end else if (any_none) begin
      verdict_nxt = VERDICT_OUTSIDE;
    end else if (all_full) begin
      verdict_nxt = VERDICT_INSIDE;
    end else begin
      verdict_nxt = VERDICT_PARTIAL;
    end
  end

  // Output register: hold the verdict until the beat is taken.
  always_ff @(posedge clk) begin
    if (v2_r && adv3) verdict_r <= verdict_nxt;
  end

  assign out_valid   = v3_r;
  assign out_verdict = verdict_r;

  // An accepted beat always lands in stage 1.
  `FCT_ASSERT_NEXT(a_in_lands, clk, rst_n, in_valid && in_ready, v1_r)
  // A stalled product stage keeps its item.
  `FCT_ASSERT_NEXT(a_stage2_holds, clk, rst_n, v2_r && !adv3, v2_r)
  // Without a beat on either side the number of items in flight does not change.
  `FCT_ASSERT_NEXT(a_conserve, clk, rst_n,
    !(in_valid && in_ready) && !(out_valid && out_ready),
    $countones({v1_r, v2_r, v3_r}) == $past($countones({v1_r, v2_r, v3_r})))
  // A sphere query never reports fully inside.
  `FCT_ASSERT_NOW(a_sphere_verdict, clk, rst_n, v2_r && sphere2_r,
    verdict_nxt != VERDICT_INSIDE)

endmodule

`default_nettype wire
